[rtl/cfcp_pkg.sv]
// Shared types and codes for the contact friction cone projection unit.
// No dependencies.
package cfcp_pkg;

  localparam int FIELD_W = 32;
  localparam int MU_W    = 18;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_LOAD     = 2'd0;
  localparam opcode_t OP_CONTACT  = 2'd1;
  localparam opcode_t OP_FRICTION = 2'd2;
  localparam opcode_t OP_RSVD     = 2'd3;

  localparam logic [1:0] ROW_LAST = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_FWD  = 11'b000_0000_0010,
    S_LSQ  = 11'b000_0000_0100,
    S_LRT  = 11'b000_0000_1000,
    S_ISQ  = 11'b000_0001_0000,
    S_IRT  = 11'b000_0010_0000,
    S_BND  = 11'b000_0100_0000,
    S_SMUL = 11'b000_1000_0000,
    S_SDIV = 11'b001_0000_0000,
    S_BWD  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

endpackage

[rtl/cfcp_if.sv]
// Request and result channel interfaces of the projection unit.
// Depends on cfcp_pkg.
interface cfcp_in_if import cfcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [1:0]                row_select;
  logic signed [FIELD_W-1:0] vec_x;
  logic signed [FIELD_W-1:0] vec_y;
  logic signed [FIELD_W-1:0] vec_z;
  logic signed [FIELD_W-1:0] imp_x;
  logic signed [FIELD_W-1:0] imp_y;
  logic signed [FIELD_W-1:0] imp_z;
  logic [MU_W-1:0]           friction_coeff;

  modport source (output valid, opcode, row_select, vec_x, vec_y, vec_z,
                  imp_x, imp_y, imp_z, friction_coeff, input ready);
  modport sink   (input valid, opcode, row_select, vec_x, vec_y, vec_z,
                  imp_x, imp_y, imp_z, friction_coeff, output ready);
endinterface

interface cfcp_out_if import cfcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic signed [FIELD_W-1:0] out_z;
  logic signed [FIELD_W-1:0] lambda_normal;
  logic signed [FIELD_W-1:0] lambda_tangent_one;
  logic signed [FIELD_W-1:0] lambda_tangent_two;
  logic                      cone_limited;

  modport source (output valid, out_x, out_y, out_z, lambda_normal,
                  lambda_tangent_one, lambda_tangent_two, cone_limited, input ready);
  modport sink   (input valid, out_x, out_y, out_z, lambda_normal,
                  lambda_tangent_one, lambda_tangent_two, cone_limited, output ready);
endinterface

[rtl/cfcp_mul.sv]
// Bit-serial shift-add multiplier of two unsigned magnitudes, one multiplier bit a cycle.
// Depends on cfcp_pkg.
module cfcp_mul import cfcp_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      sum;

  always_comb begin
    sum      = {1'b0, acc_r[AW+BW-1:BW]} + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = {{AW{1'b0}}, b};
      a_nxt    = a;
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {sum, acc_r[BW-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

[rtl/cfcp_sqrt.sv]
// Bit-serial integer square root, one root bit a cycle, floor result.
// Depends on cfcp_pkg.
module cfcp_sqrt import cfcp_pkg::*; #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] rad,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r, rad_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RW+2:0]   sh;
  logic [RW+2:0]   trial;

  always_comb begin
    sh       = {rem_r, rad_r[2*RW-1:2*RW-2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[2*RW-3:0], 2'b00};
      if (sh >= trial) begin
        rem_nxt  = (RW+1)'(sh - trial);
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = (RW+1)'(sh);
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

[rtl/cfcp_div.sv]
// Bit-serial restoring divider, one quotient bit a cycle, floor result.
// Depends on cfcp_pkg.
module cfcp_div import cfcp_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   sh;
  logic          qbit;

  always_comb begin
    sh       = {rem_r, num_r[NW-1]};
    qbit     = (sh >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? DW'(sh - {1'b0, den_r}) : DW'(sh);
      num_nxt = {num_r[NW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule

[rtl/contact_friction_cone_projection_unit.sv]
// Contact friction cone projection unit: top level sequencer and frame store.
// Depends on cfcp_pkg, cfcp_if, cfcp_mul, cfcp_sqrt and cfcp_div.
//
// A load request writes one row of the 3x3 contact frame and gives no result; a row select
// above 2 writes nothing. A projection request runs on one bit-serial multiplier, one
// bit-serial square root and one bit-serial divider, one request at a time. A contact
// request takes 18 products; a friction request adds five squares, two roots and the
// bound product, and when the cone clamps it two more products and two divides. A
// finished result waits in the output register while the next request is taken.
module contact_friction_cone_projection_unit import cfcp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cfcp_in_if.sink    in_chan,
  cfcp_out_if.source out_chan
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = (W > FIELD_W) ? W : FIELD_W;
  localparam int P  = 2 * MW;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [MW-1:0] mag_fn(input logic signed [MW-1:0] x);
    mag_fn = x[MW-1] ? MW'(-x) : MW'(x);
  endfunction

  function automatic logic signed [W-1:0] fx_fn(input logic [P-1:0] p, input logic neg);
    logic [P-F:0] q;
    logic [W-1:0] qw;
    logic         rb;
    rb = neg & (|p[F-1:0]);
    q  = {1'b0, p[P-1:F]} + {{(P-F){1'b0}}, rb};
    qw = W'(q);
    if (|(q >> (W-1))) fx_fn = neg ? WMIN : WMAX;
    else               fx_fn = neg ? W'(-qw) : qw;
  endfunction

  function automatic logic signed [W-1:0] sadd_fn(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sadd_fn = s[W] ? WMIN : WMAX;
    else                sadd_fn = s[W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] sat32_fn(input logic signed [W-1:0] x);
    logic signed [MW-1:0] t;
    t = MW'(x);
    if ((&t[MW-1:FIELD_W-1]) || ~(|t[MW-1:FIELD_W-1])) sat32_fn = t[FIELD_W-1:0];
    else sat32_fn = t[MW-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
  endfunction

  state_t                    state_r, state_nxt;
  logic signed [FIELD_W-1:0] frame_r [3][3];
  logic signed [FIELD_W-1:0] frame_nxt [3][3];
  opcode_t                   opc_r, opc_nxt;
  logic signed [FIELD_W-1:0] v_r [3];
  logic signed [FIELD_W-1:0] v_nxt [3];
  logic signed [FIELD_W-1:0] imp_r [3];
  logic signed [FIELD_W-1:0] imp_nxt [3];
  logic [MU_W-1:0]           mu_r, mu_nxt;
  logic signed [W-1:0]       lam_r [3];
  logic signed [W-1:0]       lam_nxt [3];
  logic signed [W-1:0]       res_r [3];
  logic signed [W-1:0]       res_nxt [3];
  logic signed [W-1:0]       acc_r, acc_nxt;
  logic [P-1:0]              rad_r, rad_nxt;
  logic [MW-1:0]             len_r, len_nxt;
  logic [MW-1:0]             inorm_r, inorm_nxt;
  logic [MW-1:0]             bound_r, bound_nxt;
  logic                      lim_r, lim_nxt;
  logic [1:0]                row_r, row_nxt;
  logic [1:0]                col_r, col_nxt;
  logic                      go_r, go_nxt;

  logic                      ov_r, ov_nxt;
  logic [FIELD_W-1:0]        ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [FIELD_W-1:0]        ln_r, ln_nxt, lt1_r, lt1_nxt, lt2_r, lt2_nxt;
  logic                      ocl_r, ocl_nxt;

  logic [MW-1:0]       mul_a, mul_b;
  logic                mul_neg, mul_start, mul_done;
  logic [P-1:0]        mul_prod;
  logic                rt_start, rt_done;
  logic [MW-1:0]       rt_root;
  logic                dv_start, dv_done;
  logic [P-1:0]        dv_quo;
  logic signed [W-1:0] fx_sum;
  logic [P-F-1:0]      bnd_q;
  logic [MW-1:0]       bnd_val;
  logic [W-1:0]        dv_m;
  logic                in_acc;

  assign in_acc = in_chan.valid && in_chan.ready;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state_r)
      S_FWD: begin
        mul_a   = mag_fn(MW'(frame_r[row_r][col_r]));
        mul_b   = mag_fn(MW'(v_r[col_r]));
        mul_neg = frame_r[row_r][col_r][FIELD_W-1] ^ v_r[col_r][FIELD_W-1];
      end
      S_LSQ: begin
        mul_a = mag_fn(MW'(lam_r[col_r]));
        mul_b = mag_fn(MW'(lam_r[col_r]));
      end
      S_ISQ: begin
        mul_a = mag_fn(MW'(imp_r[col_r]));
        mul_b = mag_fn(MW'(imp_r[col_r]));
      end
      S_BND: begin
        mul_a = MW'(mu_r);
        mul_b = inorm_r;
      end
      S_SMUL: begin
        mul_a = mag_fn(MW'(lam_r[col_r]));
        mul_b = bound_r;
      end
      S_BWD: begin
        mul_a   = mag_fn(MW'(frame_r[col_r][row_r]));
        mul_b   = mag_fn(MW'(lam_r[col_r]));
        mul_neg = frame_r[col_r][row_r][FIELD_W-1] ^ lam_r[col_r][W-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_start = go_r && (state_r == S_FWD || state_r == S_LSQ || state_r == S_ISQ ||
                              state_r == S_BND || state_r == S_SMUL || state_r == S_BWD);
  assign rt_start  = go_r && (state_r == S_LRT || state_r == S_IRT);
  assign dv_start  = go_r && (state_r == S_SDIV);

  cfcp_mul #(.AW(MW), .BW(MW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  cfcp_sqrt #(.RW(MW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(rt_start), .rad(rad_r),
    .done(rt_done), .root(rt_root)
  );

  cfcp_div #(.NW(P), .DW(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(mul_prod), .den(len_r),
    .done(dv_done), .quo(dv_quo)
  );

  always_comb begin
    fx_sum  = sadd_fn(acc_r, fx_fn(mul_prod, mul_neg));
    bnd_q   = mul_prod[P-1:F];
    bnd_val = (|(bnd_q >> (W-1))) ? MW'($unsigned(WMAX)) : MW'(bnd_q);
    dv_m    = W'(dv_quo);
  end

  always_comb begin
    state_nxt = state_r;
    frame_nxt = frame_r;
    opc_nxt   = opc_r;
    v_nxt     = v_r;
    imp_nxt   = imp_r;
    mu_nxt    = mu_r;
    lam_nxt   = lam_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;
    rad_nxt   = rad_r;
    len_nxt   = len_r;
    inorm_nxt = inorm_r;
    bound_nxt = bound_r;
    lim_nxt   = lim_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    go_nxt    = 1'b0;
    ov_nxt    = ov_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    ln_nxt    = ln_r;
    lt1_nxt   = lt1_r;
    lt2_nxt   = lt2_r;
    ocl_nxt   = ocl_r;

    if (out_chan.valid && out_chan.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.opcode == OP_LOAD) begin
            if (in_chan.row_select <= ROW_LAST) begin
              frame_nxt[in_chan.row_select][0] = in_chan.vec_x;
              frame_nxt[in_chan.row_select][1] = in_chan.vec_y;
              frame_nxt[in_chan.row_select][2] = in_chan.vec_z;
            end
          end else if (in_chan.opcode == OP_CONTACT || in_chan.opcode == OP_FRICTION) begin
            opc_nxt    = in_chan.opcode;
            v_nxt[0]   = in_chan.vec_x;
            v_nxt[1]   = in_chan.vec_y;
            v_nxt[2]   = in_chan.vec_z;
            imp_nxt[0] = in_chan.imp_x;
            imp_nxt[1] = in_chan.imp_y;
            imp_nxt[2] = in_chan.imp_z;
            mu_nxt     = in_chan.friction_coeff;
            lim_nxt    = 1'b0;
            acc_nxt    = '0;
            row_nxt    = 2'd0;
            col_nxt    = 2'd0;
            go_nxt     = 1'b1;
            state_nxt  = S_FWD;
          end
        end
      end
      S_FWD: begin
        if (mul_done) begin
          go_nxt = 1'b1;
          if (col_r == ROW_LAST) begin
            lam_nxt[row_r] = fx_sum;
            acc_nxt        = '0;
            col_nxt        = 2'd0;
            if (row_r == ROW_LAST) begin
              if (opc_r == OP_CONTACT) begin
                lam_nxt[0] = lam_r[0][W-1] ? '0 : lam_r[0];
                lam_nxt[1] = '0;
                lam_nxt[2] = '0;
                row_nxt    = 2'd0;
                state_nxt  = S_BWD;
              end else begin
                lam_nxt[0] = '0;
                rad_nxt    = '0;
                col_nxt    = 2'd1;
                state_nxt  = S_LSQ;
              end
            end else begin
              row_nxt = row_r + 2'd1;
            end
          end else begin
            acc_nxt = fx_sum;
            col_nxt = col_r + 2'd1;
          end
        end
      end
      S_LSQ: begin
        if (mul_done) begin
          go_nxt  = 1'b1;
          rad_nxt = rad_r + mul_prod;
          if (col_r == ROW_LAST) state_nxt = S_LRT;
          else                   col_nxt   = col_r + 2'd1;
        end
      end
      S_LRT: begin
        if (rt_done) begin
          len_nxt   = rt_root;
          rad_nxt   = '0;
          col_nxt   = 2'd0;
          go_nxt    = 1'b1;
          state_nxt = S_ISQ;
        end
      end
      S_ISQ: begin
        if (mul_done) begin
          go_nxt  = 1'b1;
          rad_nxt = rad_r + mul_prod;
          if (col_r == ROW_LAST) state_nxt = S_IRT;
          else                   col_nxt   = col_r + 2'd1;
        end
      end
      S_IRT: begin
        if (rt_done) begin
          inorm_nxt = rt_root;
          go_nxt    = 1'b1;
          state_nxt = S_BND;
        end
      end
      S_BND: begin
        if (mul_done) begin
          bound_nxt = bnd_val;
          go_nxt    = 1'b1;
          if (len_r > bnd_val) begin
            lim_nxt   = 1'b1;
            col_nxt   = 2'd1;
            state_nxt = S_SMUL;
          end else begin
            acc_nxt   = '0;
            row_nxt   = 2'd0;
            col_nxt   = 2'd0;
            state_nxt = S_BWD;
          end
        end
      end
      S_SMUL: begin
        if (mul_done) begin
          go_nxt    = 1'b1;
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        if (dv_done) begin
          go_nxt         = 1'b1;
          lam_nxt[col_r] = lam_r[col_r][W-1] ? W'(-dv_m) : dv_m;
          if (col_r == ROW_LAST) begin
            acc_nxt   = '0;
            row_nxt   = 2'd0;
            col_nxt   = 2'd0;
            state_nxt = S_BWD;
          end else begin
            col_nxt   = ROW_LAST;
            state_nxt = S_SMUL;
          end
        end
      end
      S_BWD: begin
        if (mul_done) begin
          if (col_r == ROW_LAST) begin
            res_nxt[row_r] = fx_sum;
            acc_nxt        = '0;
            col_nxt        = 2'd0;
            if (row_r == ROW_LAST) begin
              state_nxt = S_FIN;
            end else begin
              row_nxt = row_r + 2'd1;
              go_nxt  = 1'b1;
            end
          end else begin
            acc_nxt = fx_sum;
            col_nxt = col_r + 2'd1;
            go_nxt  = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          ox_nxt    = sat32_fn(res_r[0]);
          oy_nxt    = sat32_fn(res_r[1]);
          oz_nxt    = sat32_fn(res_r[2]);
          ln_nxt    = sat32_fn(lam_r[0]);
          lt1_nxt   = sat32_fn(lam_r[1]);
          lt2_nxt   = sat32_fn(lam_r[2]);
          ocl_nxt   = lim_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          frame_r[i][j] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      frame_r <= frame_nxt;
    end
    opc_r   <= opc_nxt;
    v_r     <= v_nxt;
    imp_r   <= imp_nxt;
    mu_r    <= mu_nxt;
    lam_r   <= lam_nxt;
    res_r   <= res_nxt;
    acc_r   <= acc_nxt;
    rad_r   <= rad_nxt;
    len_r   <= len_nxt;
    inorm_r <= inorm_nxt;
    bound_r <= bound_nxt;
    lim_r   <= lim_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    ln_r    <= ln_nxt;
    lt1_r   <= lt1_nxt;
    lt2_r   <= lt2_nxt;
    ocl_r   <= ocl_nxt;
  end

  assign in_chan.ready               = (state_r == S_IDLE);
  assign out_chan.valid              = ov_r;
  assign out_chan.out_x              = ox_r;
  assign out_chan.out_y              = oy_r;
  assign out_chan.out_z              = oz_r;
  assign out_chan.lambda_normal      = ln_r;
  assign out_chan.lambda_tangent_one = lt1_r;
  assign out_chan.lambda_tangent_two = lt2_r;
  assign out_chan.cone_limited       = ocl_r;

  a_proj_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.opcode == OP_CONTACT || in_chan.opcode == OP_FRICTION)
    |=> state_r == S_FWD)
    else $error("projection request did not start the forward map");

  a_normal_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !out_chan.lambda_normal[FIELD_W-1])
    else $error("negative normal multiplier");

  a_contact_no_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.lambda_normal != '0
    |-> out_chan.lambda_tangent_one == '0 && out_chan.lambda_tangent_two == '0
        && !out_chan.cone_limited)
    else $error("contact result carries tangent terms");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_start, rt_start, dv_start}))
    else $error("two arithmetic units started together");

  a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r != S_IDLE && state_r != S_FIN)
    else $error("product finished outside a projection");

endmodule
